// File: rtl/fat12cce_pkg.sv
// Shared types and constants of the FAT12 cluster chain engine.
package fat12cce_pkg;

    // Controller states, one-hot
    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_LOOKUP = 5'b00100,
        ST_SCAN   = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    // Request codes
    typedef enum logic [1:0] {
        REQ_FOLLOW  = 2'd0,
        REQ_FIND    = 2'd1,
        REQ_SET     = 2'd2,
        REQ_ADVANCE = 2'd3
    } req_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_END_BOUND = 2'd0;
    localparam logic [1:0] CFG_DATA_BASE = 2'd1;
    localparam logic [1:0] CFG_SECT_LEN  = 2'd2;

    // Field widths
    localparam int ENTRY_W = 12;
    localparam int ADDR_W  = 24;
    localparam int SLEN_W  = 13;
    localparam int IN_W    = 32;
    localparam int OUT_W   = 56;

    // Entry values
    localparam logic [ENTRY_W-1:0] ENTRY_FULL  = 12'hFFF;
    localparam logic [ENTRY_W-1:0] ENTRY_FREE  = 12'h000;
    localparam logic [ENTRY_W-1:0] FIRST_DATA  = 12'd2;

    // Register reset values
    localparam logic [ENTRY_W-1:0] END_BOUND_RST = 12'd4095;
    localparam logic [ADDR_W-1:0]  DATA_BASE_RST = 24'd0;
    localparam logic [SLEN_W-1:0]  SECT_LEN_RST  = 13'd512;

endpackage

// File: rtl/fat12_cluster_chain_engine_top.sv
// FAT12 cluster chain engine: link table in a synchronous memory with a scan sequencer.
//
// Channel   Direction  Handshake         Contents
// s_*       in         s_tvalid/tready   one request: type, cluster, link value
// m_*       out        m_tvalid/tready   one result: status, clusters, data address
// cfg_*     in         cfg_we            register index and write data
//
// Follow and set link pass through the lookup and done states from transfer to
// result; find free and advance-with-allocation also pass through the scan, which
// reads one table entry per cycle through the single memory read port.
// After reset a clearing pass writes zero to all TABLE_DEPTH entries, one per
// cycle, before the first request is taken. A result waits in the output
// register while the master side stalls; the next request is taken once the
// result has moved into that register.
module fat12_cluster_chain_engine_top #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [fat12cce_pkg::ADDR_W-1:0] cfg_data,
    // request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [1:0] req_type, [13:2] cluster, [25:14] link_value, [31:26] zero
    input  logic [fat12cce_pkg::IN_W-1:0]   s_tdata,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] status, [12:1] result_cluster, [24:13] previous_cluster,
    // [48:25] data_address, [55:49] zero
    output logic [fat12cce_pkg::OUT_W-1:0]  m_tdata
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);
    localparam logic [12:0] DEPTH13 = 13'(TABLE_DEPTH);
    localparam int SCAN_END_I = (TABLE_DEPTH < 4095) ? TABLE_DEPTH : 4095;
    localparam logic [11:0] SCAN_END = 12'(SCAN_END_I);

    // Link table memory
    logic [11:0] mem [TABLE_DEPTH];
    logic [AW-1:0] rd_addr;
    logic [11:0] rd_data_reg;
    logic mem_we;
    logic [AW-1:0] wr_addr;
    logic [11:0] wr_data;

    // Configuration registers
    logic [11:0] bound_reg;
    logic [23:0] base_reg;
    logic [12:0] slen_reg;

    // Control
    fat12cce_pkg::state_t state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [11:0] scan_cnt_reg, scan_cnt_next;
    logic pend_reg, pend_next;
    logic [11:0] pend_addr_reg, pend_addr_next;
    logic seen_reg, seen_next;
    logic alloc_reg, alloc_next;
    logic m_tvalid_reg, m_tvalid_next;

    // Request and result payload
    logic [1:0] req_reg;
    logic [11:0] clus_reg;
    logic [11:0] lv_reg;
    logic in_range_reg;
    logic status_reg, status_next;
    logic [11:0] res_reg, res_next;
    logic [23:0] prod_reg;
    logic o_status_reg;
    logic [11:0] o_res_reg, o_prev_reg;
    logic [23:0] o_addr_reg;

    logic accept;
    logic load_out;
    logic [1:0] in_req;
    logic [11:0] in_clus, in_lv;
    logic follow_ok;
    logic [11:0] link_val;
    logic [23:0] cm2;
    logic [36:0] prod_full;

    assign in_req  = s_tdata[1:0];
    assign in_clus = s_tdata[13:2];
    assign in_lv   = s_tdata[25:14];

    assign s_tready = (state_reg == fat12cce_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, o_addr_reg, o_prev_reg, o_res_reg, o_status_reg};

    // Follow validity and the looked-up link (entries beyond the table are full)
    assign follow_ok = (clus_reg >= fat12cce_pkg::FIRST_DATA) && (clus_reg < bound_reg);
    assign link_val  = in_range_reg ? rd_data_reg : fat12cce_pkg::ENTRY_FULL;

    // Data address product, cluster minus two taken modulo 2^24
    assign cm2       = {12'd0, clus_reg} - 24'd2;
    assign prod_full = 37'(slen_reg) * 37'(cm2);

    // Memory port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_reg <= fat12cce_pkg::END_BOUND_RST;
            base_reg  <= fat12cce_pkg::DATA_BASE_RST;
            slen_reg  <= fat12cce_pkg::SECT_LEN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fat12cce_pkg::CFG_END_BOUND: bound_reg <= cfg_data[11:0];
                fat12cce_pkg::CFG_DATA_BASE: base_reg  <= cfg_data;
                fat12cce_pkg::CFG_SECT_LEN:  slen_reg  <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        scan_cnt_next  = scan_cnt_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        seen_next      = seen_reg;
        alloc_next     = alloc_reg;
        status_next    = status_reg;
        res_next       = res_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        load_out       = 1'b0;
        rd_addr        = in_clus[AW-1:0];
        mem_we         = 1'b0;
        wr_addr        = clus_reg[AW-1:0];
        wr_data        = res_reg;

        case (state_reg)
            fat12cce_pkg::ST_CLEAR:
            begin
                mem_we       = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = fat12cce_pkg::ENTRY_FREE;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == LAST_IDX)
                begin
                    state_next = fat12cce_pkg::ST_IDLE;
                end
            end
            fat12cce_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    // set link writes straight away when the cluster lies in the table; the read made then is unused
                    if ((in_req == fat12cce_pkg::REQ_SET) && ({1'b0, in_clus} < DEPTH13))
                    begin
                        mem_we  = 1'b1;
                        wr_addr = in_clus[AW-1:0];
                        wr_data = in_lv;
                    end
                    state_next = fat12cce_pkg::ST_LOOKUP;
                end
            end
            fat12cce_pkg::ST_LOOKUP:
            begin
                status_next   = 1'b0;
                res_next      = fat12cce_pkg::ENTRY_FREE;
                alloc_next    = 1'b0;
                scan_cnt_next = 12'd0;
                seen_next     = 1'b0;
                state_next    = fat12cce_pkg::ST_DONE;
                case (req_reg)
                    fat12cce_pkg::REQ_FOLLOW:
                    begin
                        if (follow_ok)
                        begin
                            res_next = link_val;
                        end
                        else
                        begin
                            status_next = 1'b1;
                        end
                    end
                    fat12cce_pkg::REQ_FIND:
                    begin
                        state_next = fat12cce_pkg::ST_SCAN;
                    end
                    fat12cce_pkg::REQ_SET:
                    begin
                        res_next = lv_reg;
                    end
                    fat12cce_pkg::REQ_ADVANCE:
                    begin
                        if (!follow_ok)
                        begin
                            status_next = 1'b1;
                        end
                        else if (link_val != fat12cce_pkg::ENTRY_FREE)
                        begin
                            res_next = link_val;
                        end
                        else
                        begin
                            alloc_next = 1'b1;
                            state_next = fat12cce_pkg::ST_SCAN;
                        end
                    end
                    default: ;
                endcase
            end
            fat12cce_pkg::ST_SCAN:
            begin
                // issue the next read
                rd_addr = scan_cnt_reg[AW-1:0];
                if (scan_cnt_reg < SCAN_END)
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = scan_cnt_reg;
                    scan_cnt_next  = scan_cnt_reg + 12'd1;
                end
                // judge the entry read last cycle; the first free one is skipped, as is the request's own cluster
                if (pend_reg && (rd_data_reg == fat12cce_pkg::ENTRY_FREE))
                begin
                    if (seen_reg && (pend_addr_reg != clus_reg))
                    begin
                        res_next   = pend_addr_reg;
                        state_next = fat12cce_pkg::ST_DONE;
                    end
                    else
                    begin
                        seen_next = 1'b1;
                    end
                end
                else if (!pend_reg && (scan_cnt_reg == SCAN_END))
                begin
                    res_next   = fat12cce_pkg::ENTRY_FULL;
                    state_next = fat12cce_pkg::ST_DONE;
                end
                // allocation links the found cluster, or FFF when none is free, into the current one
                if ((state_next == fat12cce_pkg::ST_DONE) && alloc_reg && in_range_reg)
                begin
                    mem_we  = 1'b1;
                    wr_addr = clus_reg[AW-1:0];
                    wr_data = res_next;
                end
            end
            fat12cce_pkg::ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    load_out      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = fat12cce_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fat12cce_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fat12cce_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            scan_cnt_reg  <= '0;
            pend_reg      <= 1'b0;
            seen_reg      <= 1'b0;
            alloc_reg     <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            scan_cnt_reg  <= scan_cnt_next;
            pend_reg      <= pend_next;
            seen_reg      <= seen_next;
            alloc_reg     <= alloc_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        status_reg    <= status_next;
        res_reg       <= res_next;
        if (accept)
        begin
            req_reg      <= in_req;
            clus_reg     <= in_clus;
            lv_reg       <= in_lv;
            in_range_reg <= ({1'b0, in_clus} < DEPTH13);
        end
        if (state_reg == fat12cce_pkg::ST_LOOKUP)
        begin
            prod_reg <= prod_full[23:0];
        end
        if (load_out)
        begin
            o_status_reg <= status_reg;
            o_res_reg    <= res_reg;
            o_prev_reg   <= clus_reg;
            o_addr_reg   <= base_reg + prod_reg;
        end
    end

    // Checks
    a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == fat12cce_pkg::ST_LOOKUP))
        else $error("request transfer not followed by lookup");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_cnt_reg <= SCAN_END)
        else $error("scan counter beyond end");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[12:1] == fat12cce_pkg::ENTRY_FREE))
        else $error("chain error with nonzero cluster");

    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fat12cce_pkg::ST_CLEAR) |-> (mem_we && (wr_data == fat12cce_pkg::ENTRY_FREE)))
        else $error("clearing pass writes nonzero entry");

endmodule
